FILE: src/fill_rect_clip_command_gen_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fill-rectangle command generator
// Clocked concurrent assertions with an active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef FILL_RECT_CLIP_COMMAND_GEN_ASSERT_SVH
`define FILL_RECT_CLIP_COMMAND_GEN_ASSERT_SVH

// Same-cycle implication: ante holds, so cons holds in that cycle
`define FRC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("fill_rect_clip_command_gen: assertion failed");

// Next-cycle implication: ante holds, so cons holds in the next cycle
`define FRC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("fill_rect_clip_command_gen: assertion failed");

`endif

FILE: src/frc_pkg.sv
// ----------------------------------------------------------------------------
// frc_pkg
// Shared types and constants of the fill-rectangle command generator.
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  // Display controller command codes
  localparam logic [15:0] CmdColumnSet = 16'h002A;
  localparam logic [15:0] CmdRowSet    = 16'h002B;
  localparam logic [15:0] CmdMemWrite  = 16'h002C;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] RegScreenWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegScreenHeight = 2'd1;

  localparam int unsigned ScreenW = 10;
  localparam logic [ScreenW-1:0] ScreenWidthRst  = 10'd240;
  localparam logic [ScreenW-1:0] ScreenHeightRst = 10'd320;

  // Queue between classifier and command sequencer
  localparam int unsigned QDepth = 4;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = $clog2(QDepth + 1);

  localparam int unsigned CountW = 20;

  // One clipped rectangle, ready for command generation
  typedef struct packed {
    logic [15:0] x1;
    logic [15:0] x2;
    logic [15:0] y1;
    logic [15:0] y2;
    logic [15:0] w;
    logic [15:0] h;
    logic [15:0] color;
  } rect_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic             empty;
    logic [QCntW-1:0] count;
  } q_status_t;

endpackage

`default_nettype wire

FILE: src/frc_front.sv
// ----------------------------------------------------------------------------
// frc_front
// Accepts rectangle requests, normalizes negative sizes, drops empty and
// off-screen requests and clips the rest to the screen.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic signed [15:0]            origin_x_i,
  input  logic signed [15:0]            origin_y_i,
  input  logic signed [15:0]            rect_width_i,
  input  logic signed [15:0]            rect_height_i,
  input  logic [15:0]                   fill_color_i,
  input  logic [frc_pkg::ScreenW-1:0]   screen_width_i,
  input  logic [frc_pkg::ScreenW-1:0]   screen_height_i,
  input  frc_pkg::q_status_t            q_stat_i,
  output logic                          push_o,
  output frc_pkg::rect_entry_t          push_data_o
);
  import frc_pkg::*;

  localparam logic [QCntW:0] DepthLim = (QCntW + 1)'(QDepth);

  logic               accept;
  logic               zero_size;
  logic signed [15:0] x_n, y_n, w_n, h_n;

  logic               a_valid_q;
  logic signed [15:0] xa_q, ya_q, wa_q, ha_q;
  logic [15:0]        col_q;

  logic signed [15:0] sw16, sh16;
  logic signed [15:0] xe, ye;
  logic               x_over, y_over;
  logic               keep;
  logic signed [15:0] xc, yc, w_lo, h_lo, wc, hc, x2, y2;

  // Hold off new requests while in-flight items could overfill the queue
  assign busy_o = ({1'b0, q_stat_i.count} + {{QCntW{1'b0}}, a_valid_q}) >= DepthLim;
  assign accept = start_i && !busy_o;

  // Turn negative sizes around so the rectangle grows from the far edge
  always_comb begin
    zero_size = (rect_width_i == 16'sd0) || (rect_height_i == 16'sd0);
    if (rect_width_i[15]) begin
      x_n = origin_x_i + rect_width_i + 16'sd1;
      w_n = -rect_width_i;
    end else begin
      x_n = origin_x_i;
      w_n = rect_width_i;
    end
    if (rect_height_i[15]) begin
      y_n = origin_y_i + rect_height_i + 16'sd1;
      h_n = -rect_height_i;
    end else begin
      y_n = origin_y_i;
      h_n = rect_height_i;
    end
  end

  // Normalize stage: drop zero-size requests here
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else begin
      a_valid_q <= accept && !zero_size;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xa_q  <= x_n;
      ya_q  <= y_n;
      wa_q  <= w_n;
      ha_q  <= h_n;
      col_q <= fill_color_i;
    end
  end

  // Classify against the screen and clip
  always_comb begin
    sw16   = $signed({6'b0, screen_width_i});
    sh16   = $signed({6'b0, screen_height_i});
    xe     = xa_q + wa_q - 16'sd1;
    ye     = ya_q + ha_q - 16'sd1;
    x_over = xe >= sw16;
    y_over = ye >= sh16;
    keep   = !(xa_q >= sw16) && !(ya_q >= sh16) && !xe[15] && !ye[15];

    xc   = xa_q[15] ? 16'sd0 : xa_q;
    yc   = ya_q[15] ? 16'sd0 : ya_q;
    w_lo = xa_q[15] ? xe + 16'sd1 : wa_q;
    h_lo = ya_q[15] ? ye + 16'sd1 : ha_q;
    wc   = x_over ? sw16 - xc : w_lo;
    hc   = y_over ? sh16 - yc : h_lo;
    // Far edge is the screen edge when clipped, else the unclipped edge
    x2   = x_over ? sw16 - 16'sd1 : xe;
    y2   = y_over ? sh16 - 16'sd1 : ye;
  end

  assign push_o            = a_valid_q && keep;
  assign push_data_o.x1    = xc;
  assign push_data_o.x2    = x2;
  assign push_data_o.y1    = yc;
  assign push_data_o.y2    = y2;
  assign push_data_o.w     = wc;
  assign push_data_o.h     = hc;
  assign push_data_o.color = col_q;

endmodule

`default_nettype wire

FILE: src/frc_queue.sv
// ----------------------------------------------------------------------------
// frc_queue
// Short FIFO of clipped rectangles between classifier and sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  frc_pkg::rect_entry_t push_data_i,
  input  logic                 pop_i,
  output frc_pkg::rect_entry_t pop_data_o,
  output frc_pkg::q_status_t   stat_o
);
  import frc_pkg::*;

  rect_entry_t      mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q, count_d;

  // Store pushed entries
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Track occupancy
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  assign pop_data_o   = mem_q[rd_ptr_q];
  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);

endmodule

`default_nettype wire

FILE: src/frc_back.sv
// ----------------------------------------------------------------------------
// frc_back
// Sequencer that turns one clipped rectangle into seven command and data
// words and forms the pixel count.
// ----------------------------------------------------------------------------
`default_nettype none

module frc_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  frc_pkg::q_status_t            q_stat_i,
  input  frc_pkg::rect_entry_t          q_data_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  output logic [15:0]                   out_word_o,
  output logic                          is_command_o,
  output logic [frc_pkg::CountW-1:0]    pixel_count_o,
  output logic [15:0]                   color_out_o,
  output logic                          last_o
);
  import frc_pkg::*;

  typedef enum logic [2:0] {
    StIdle,
    StColSet,
    StX1,
    StX2,
    StRowSet,
    StY1,
    StY2,
    StMemWr
  } step_e;

  step_e              state_q, state_d;
  rect_entry_t        ent_q;
  logic [CountW-1:0]  prod_q;
  logic [CountW-1:0]  w_ext, h_ext;
  logic [2*CountW-1:0] prod_full;

  // Take the next rectangle when idle or on the final word
  assign pop_o = !q_stat_i.empty && ((state_q == StIdle) || (state_q == StMemWr));

  always_comb begin
    case (state_q)
      StIdle:   state_d = pop_o ? StColSet : StIdle;
      StColSet: state_d = StX1;
      StX1:     state_d = StX2;
      StX2:     state_d = StRowSet;
      StRowSet: state_d = StY1;
      StY1:     state_d = StY2;
      StY2:     state_d = StMemWr;
      StMemWr:  state_d = pop_o ? StColSet : StIdle;
      default:  state_d = StIdle;
    endcase
  end

  // Latch the popped entry
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      ent_q <= q_data_i;
    end
  end

  // Pixel count: low bits of the product of the sign-extended sizes
  assign w_ext     = {{(CountW - 16){ent_q.w[15]}}, ent_q.w};
  assign h_ext     = {{(CountW - 16){ent_q.h[15]}}, ent_q.h};
  assign prod_full = w_ext * h_ext;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_full[CountW-1:0];
  end

  // Step state and drive the registered result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      out_valid_o   <= 1'b0;
      out_word_o    <= '0;
      is_command_o  <= 1'b0;
      pixel_count_o <= '0;
      color_out_o   <= '0;
      last_o        <= 1'b0;
    end else begin
      state_q       <= state_d;
      out_valid_o   <= (state_q != StIdle);
      out_word_o    <= '0;
      is_command_o  <= 1'b0;
      pixel_count_o <= '0;
      color_out_o   <= '0;
      last_o        <= 1'b0;
      case (state_q)
        StIdle: begin
        end
        StColSet: begin
          out_word_o   <= CmdColumnSet;
          is_command_o <= 1'b1;
        end
        StX1:     out_word_o <= ent_q.x1;
        StX2:     out_word_o <= ent_q.x2;
        StRowSet: begin
          out_word_o   <= CmdRowSet;
          is_command_o <= 1'b1;
        end
        StY1:     out_word_o <= ent_q.y1;
        StY2:     out_word_o <= ent_q.y2;
        StMemWr: begin
          out_word_o    <= CmdMemWrite;
          is_command_o  <= 1'b1;
          pixel_count_o <= prod_q;
          color_out_o   <= ent_q.color;
          last_o        <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/fill_rect_clip_command_gen.sv
// A taken request is registered in the normalize stage, clipped and queued;
// the command sequencer then pops it and emits one word per cycle, seven per
// visible rectangle, memory-write last; dropped requests take no sequencer time.
// A four-entry queue lets new requests enter while words are still going out.
// Reset: screen size returns to 240 x 320, queue empties, no result pending.
// Results cannot be stalled; each word is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// fill_rect_clip_command_gen
// Clips a filled-rectangle request to the screen and emits the column,
// row and memory-write command sequence for a display controller.
// ----------------------------------------------------------------------------
`default_nettype none

module fill_rect_clip_command_gen (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            origin_x_i,
  input  logic signed [15:0]            origin_y_i,
  input  logic signed [15:0]            rect_width_i,
  input  logic signed [15:0]            rect_height_i,
  input  logic [15:0]                   fill_color_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [frc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [frc_pkg::ScreenW-1:0]   cfg_data_i,
  output logic                          out_valid_o,
  output logic [15:0]                   out_word_o,
  output logic                          is_command_o,
  output logic [frc_pkg::CountW-1:0]    pixel_count_o,
  output logic [15:0]                   color_out_o,
  output logic                          last_o
);
  import frc_pkg::*;

  logic [ScreenW-1:0] screen_width_q, screen_height_q;
  logic               push, pop;
  rect_entry_t        push_data, pop_data;
  q_status_t          q_stat;

  // Configuration writes are never back-pressured: ready is tied high
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_width_q  <= ScreenWidthRst;
      screen_height_q <= ScreenHeightRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        RegScreenWidth:  screen_width_q  <= cfg_data_i;
        RegScreenHeight: screen_height_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  frc_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_o          (busy),
    .origin_x_i      (origin_x_i),
    .origin_y_i      (origin_y_i),
    .rect_width_i    (rect_width_i),
    .rect_height_i   (rect_height_i),
    .fill_color_i    (fill_color_i),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .q_stat_i        (q_stat),
    .push_o          (push),
    .push_data_o     (push_data)
  );

  frc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  frc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_stat_i      (q_stat),
    .q_data_i      (pop_data),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_word_o    (out_word_o),
    .is_command_o  (is_command_o),
    .pixel_count_o (pixel_count_o),
    .color_out_o   (color_out_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

FILE: src/frc_checker.sv
// ----------------------------------------------------------------------------
// frc_checker
// Port-level checks on the result word sequence of the command generator.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fill_rect_clip_command_gen_assert.svh"

module frc_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        out_valid_o,
  input  logic [15:0]                 out_word_o,
  input  logic                        is_command_o,
  input  logic [frc_pkg::CountW-1:0]  pixel_count_o,
  input  logic [15:0]                 color_out_o,
  input  logic                        last_o
);
  import frc_pkg::*;

  logic col_set;
  logic mem_wr;
  logic quiet;

  assign col_set = out_valid_o && is_command_o && (out_word_o == CmdColumnSet);
  assign mem_wr  = out_valid_o && is_command_o && (out_word_o == CmdMemWrite);
  assign quiet   = (pixel_count_o == '0) && (color_out_o == '0);

  // The final word is always the memory-write command
  `FRC_ASSERT_IMP(a_last_is_mem_write, clk_i, rst_ni, last_o, mem_wr)
  // A column-set command opens a burst that ends with last_o set
  `FRC_ASSERT_IMP(a_burst_length, clk_i, rst_ni, col_set, ##6 last_o)
  // The column-set command is followed directly by its start coordinate
  `FRC_ASSERT_NXT(a_col_then_data, clk_i, rst_ni, col_set, out_valid_o && !is_command_o)
  // Count and color stay zero except on the final word
  `FRC_ASSERT_IMP(a_quiet_fields, clk_i, rst_ni, !last_o, quiet)

endmodule

bind fill_rect_clip_command_gen frc_checker u_frc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_word_o    (out_word_o),
  .is_command_o  (is_command_o),
  .pixel_count_o (pixel_count_o),
  .color_out_o   (color_out_o),
  .last_o        (last_o)
);

`default_nettype wire

FILE: sim/tb_fill_rect_clip_command_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fill_rect_clip_command_gen
// Self-checking bench for the fill-rectangle clip and command generator.
// Feeds directed corner cases and biased random rectangles through the start
// and busy handshake under several screen sizes. A built-in clipper predicts
// the seven-word window sequence for every accepted transaction that is not
// dropped, and each strobed output word is checked field by field.
// ----------------------------------------------------------------------------

module tb_fill_rect_clip_command_gen;
  import frc_pkg::*;

  // Index with no register behind it; writes there must be ignored
  localparam logic [CfgIdxW-1:0] RegSpare = 2'd3;
  localparam int unsigned IdlePause = 12;
  localparam int unsigned MaxPrinted = 50;

  typedef struct {
    shortint     ox;
    shortint     oy;
    shortint     rw;
    shortint     rh;
    logic [15:0] color;
  } rect_req_t;

  typedef struct {
    logic [15:0]       word;
    logic              is_cmd;
    logic [CountW-1:0] count;
    logic [15:0]       color;
    logic              is_last;
  } window_word_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [15:0]   origin_x_i = '0;
  logic signed [15:0]   origin_y_i = '0;
  logic signed [15:0]   rect_width_i = '0;
  logic signed [15:0]   rect_height_i = '0;
  logic [15:0]          fill_color_i = '0;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [ScreenW-1:0]   cfg_data_i = '0;
  logic                 out_valid_o;
  logic [15:0]          out_word_o;
  logic                 is_command_o;
  logic [CountW-1:0]    pixel_count_o;
  logic [15:0]          color_out_o;
  logic                 last_o;

  rect_req_t    rect_q[$];
  window_word_t window_q[$];
  int           scr_w = 240;
  int           scr_h = 320;
  int           mismatch_cnt = 0;
  logic         take_seen = 1'b0;
  int           burst_left = 6;
  int           gap_left = 0;

  fill_rect_clip_command_gen dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .origin_x_i    (origin_x_i),
    .origin_y_i    (origin_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .fill_color_i  (fill_color_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_valid_o   (out_valid_o),
    .out_word_o    (out_word_o),
    .is_command_o  (is_command_o),
    .pixel_count_o (pixel_count_o),
    .color_out_o   (color_out_o),
    .last_o        (last_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrinted) begin
      $display("%0t: mismatch: %s", $time, what);
    end
  endtask

  // Clip one rectangle to the screen and queue the window words it yields
  function automatic void clip_to_window(input rect_req_t r);
    shortint           x;
    shortint           y;
    shortint           w;
    shortint           h;
    shortint           xe;
    shortint           ye;
    logic [15:0]       ux;
    logic [15:0]       uy;
    logic [15:0]       uw;
    logic [15:0]       uh;
    logic [31:0]       prod;
    x = r.ox;
    y = r.oy;
    w = r.rw;
    h = r.rh;
    if (w == 0 || h == 0) return;
    // Flip negative sizes so the rectangle grows from the far edge
    if (w < 0) begin
      x = shortint'(x + w + 1);
      w = -w;
    end
    if (x >= scr_w) return;
    if (h < 0) begin
      y = shortint'(y + h + 1);
      h = -h;
    end
    if (y >= scr_h) return;
    xe = shortint'(x + w - 1);
    if (xe < 0) return;
    ye = shortint'(y + h - 1);
    if (ye < 0) return;
    // Trim to the visible area
    if (x < 0) begin
      x = 0;
      w = shortint'(xe + 1);
    end
    if (y < 0) begin
      y = 0;
      h = shortint'(ye + 1);
    end
    if (xe >= scr_w) w = shortint'(scr_w - x);
    if (ye >= scr_h) h = shortint'(scr_h - y);
    ux = x;
    uy = y;
    uw = w;
    uh = h;
    prod = int'(w) * int'(h);
    window_q.push_back('{CmdColumnSet, 1'b1, '0, '0, 1'b0});
    window_q.push_back('{ux, 1'b0, '0, '0, 1'b0});
    window_q.push_back('{ux + uw - 16'd1, 1'b0, '0, '0, 1'b0});
    window_q.push_back('{CmdRowSet, 1'b1, '0, '0, 1'b0});
    window_q.push_back('{uy, 1'b0, '0, '0, 1'b0});
    window_q.push_back('{uy + uh - 16'd1, 1'b0, '0, '0, 1'b0});
    window_q.push_back('{CmdMemWrite, 1'b1, prod[CountW-1:0], r.color, 1'b1});
  endfunction

  // Predict on every accepted transaction, then check strobed words
  always @(posedge clk_i) begin : predict_and_check
    window_word_t exp_w;
    if (!rst_ni) begin
      take_seen <= 1'b0;
    end else begin
      take_seen <= start && !busy;
      if (start && !busy) begin
        clip_to_window('{origin_x_i, origin_y_i, rect_width_i, rect_height_i,
                         fill_color_i});
      end
      if (out_valid_o) begin
        if (window_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %h", out_word_o));
        end else begin
          exp_w = window_q.pop_front();
          if (out_word_o !== exp_w.word)
            report_mismatch($sformatf("out_word %h, want %h", out_word_o, exp_w.word));
          if (is_command_o !== exp_w.is_cmd)
            report_mismatch($sformatf("is_command %b, want %b", is_command_o,
                                      exp_w.is_cmd));
          if (pixel_count_o !== exp_w.count)
            report_mismatch($sformatf("pixel_count %0d, want %0d", pixel_count_o,
                                      exp_w.count));
          if (color_out_o !== exp_w.color)
            report_mismatch($sformatf("color_out %h, want %h", color_out_o,
                                      exp_w.color));
          if (last_o !== exp_w.is_last)
            report_mismatch($sformatf("last %b, want %b", last_o, exp_w.is_last));
        end
      end
    end
  end

  // Present queued rectangles in bursts with random gaps
  always @(negedge clk_i) begin : drive_rects
    logic go;
    if (rst_ni) begin
      if (start && take_seen) begin
        rect_q.delete(0);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          burst_left = $urandom_range(1, 24);
        end
      end
      go = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (rect_q.size() > 0) begin
        go = 1'b1;
      end
      start <= go;
      if (go) begin
        origin_x_i    <= rect_q[0].ox;
        origin_y_i    <= rect_q[0].oy;
        rect_width_i  <= rect_q[0].rw;
        rect_height_i <= rect_q[0].rh;
        fill_color_i  <= rect_q[0].color;
      end else begin
        // Scramble the payload while idle; it must be ignored
        origin_x_i    <= 16'($urandom_range(0, 65535));
        origin_y_i    <= 16'($urandom_range(0, 65535));
        rect_width_i  <= 16'($urandom_range(0, 65535));
        rect_height_i <= 16'($urandom_range(0, 65535));
        fill_color_i  <= 16'($urandom_range(0, 65535));
      end
    end
  end

  task automatic add_rect(input shortint x, input shortint y, input shortint w,
                          input shortint h, input logic [15:0] c);
    rect_q.push_back('{x, y, w, h, c});
  endtask

  function automatic shortint pick_coord(input int span);
    case ($urandom_range(0, 9))
      0: pick_coord = shortint'($urandom_range(0, 65535));
      1: begin
        case ($urandom_range(0, 3))
          0: pick_coord = -32768;
          1: pick_coord = 32767;
          2: pick_coord = -1;
          default: pick_coord = 0;
        endcase
      end
      default: pick_coord = shortint'(int'($urandom_range(0, 2 * span + 80)) - span - 40);
    endcase
  endfunction

  function automatic shortint pick_size(input int span);
    int v;
    case ($urandom_range(0, 9))
      0: pick_size = shortint'($urandom_range(0, 65535));
      1: pick_size = 0;
      2: begin
        case ($urandom_range(0, 3))
          0: pick_size = -32768;
          1: pick_size = 32767;
          2: pick_size = -1;
          default: pick_size = 1;
        endcase
      end
      default: begin
        v = int'($urandom_range(1, span + 40));
        if ($urandom_range(0, 1) == 1) v = -v;
        pick_size = shortint'(v);
      end
    endcase
  endfunction

  // Write one register through the config channel and track it
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ScreenW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      RegScreenWidth:  scr_w = int'(val);
      RegScreenHeight: scr_h = int'(val);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Hold until every request is taken and every predicted word has come out
  task automatic wait_idle();
    while (rect_q.size() != 0 || start || window_q.size() != 0) @(negedge clk_i);
    repeat (IdlePause) @(negedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned phase_w[6];
    int unsigned phase_h[6];
    phase_w = '{1, 1023, 0, 0, 0, 320};
    phase_h = '{1, 1023, 1023, 0, 0, 240};
    phase_w[3] = $urandom_range(1, 1023);
    phase_h[3] = $urandom_range(1, 1023);
    phase_w[4] = $urandom_range(1, 64);
    phase_h[4] = $urandom_range(1, 64);

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners at the reset screen size
    add_rect(10, 20, 30, 40, 16'h1234);
    add_rect(10, 20, 0, 40, 16'hFFFF);
    add_rect(10, 20, 30, 0, 16'hFFFF);
    add_rect(50, 60, -20, -30, 16'hA5A5);
    add_rect(100, 100, -32768, 5, 16'h0F0F);
    add_rect(100, 100, 5, -32768, 16'hF0F0);
    add_rect(32767, 32767, 32767, 32767, 16'h0001);
    add_rect(-32768, -32768, 32767, 32767, 16'h8000);
    add_rect(-32768, 0, -32768, 1, 16'h5555);
    add_rect(240, 10, 5, 5, 16'hFFFF);
    add_rect(10, 320, 5, 5, 16'hFFFF);
    add_rect(-10, 10, 10, 5, 16'hFFFF);
    add_rect(10, -10, 5, 10, 16'hFFFF);
    add_rect(-5, 10, 20, 5, 16'h00FF);
    add_rect(230, 10, 20, 5, 16'hFF00);
    add_rect(10, -5, 5, 20, 16'h3333);
    add_rect(10, 310, 5, 20, 16'hCCCC);
    add_rect(-5, -5, 1000, 1000, 16'h7E0F);
    add_rect(0, 0, 1, 1, 16'h0000);
    add_rect(239, 319, 1, 1, 16'hFFFF);
    add_rect(0, 5, 240, 1, 16'hF800);
    add_rect(5, 0, 1, 320, 16'h07E0);
    add_rect(-1, 0, 2, -1, 16'h001F);
    add_rect(-1, -1, 32767, 32767, 16'hAAAA);
    wait_idle();

    // A write to an unused index must change nothing
    write_reg(RegSpare, 10'h3FF);

    // Random rectangles under a range of screen sizes
    foreach (phase_w[p]) begin
      write_reg(RegScreenWidth, phase_w[p][ScreenW-1:0]);
      write_reg(RegScreenHeight, phase_h[p][ScreenW-1:0]);
      add_rect(-1, -1, 32767, 32767, 16'($urandom_range(0, 65535)));
      repeat (28) begin
        add_rect(pick_coord(scr_w), pick_coord(scr_h), pick_size(scr_w),
                 pick_size(scr_h), 16'($urandom_range(0, 65535)));
      end
      wait_idle();
    end

    if (mismatch_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // End a hung run
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
